// File: rtl/core/ufea_pkg.sv
// ----------------------------------------------------------------------------
// ufea_pkg
// Shared types and constants of the union-find edge acceptor.
// ----------------------------------------------------------------------------
package ufea_pkg;

   // forest size and field widths
   localparam int MAX_NODES = 256;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int COUNT_W   = NODE_W + 1;
   localparam int OP_W      = 2;

   // reset value of the node count register
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_NODES);

   // item opcodes
   typedef enum logic [OP_W-1:0] {
      OP_EDGE  = 2'd0,
      OP_FIND  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;   // latch the item, cur = endpoint_a, clear result
      logic set_err;    // flag a range error
      logic rd_issue;   // read the parent link of cur
      logic step;       // cur moves up to its parent
      logic save_a;     // cur is the root of endpoint_a
      logic sel_b;      // cur = endpoint_b
      logic save_b;     // cur is the root of endpoint_b
      logic link;       // link root_b under root_a
      logic clr_forest; // every node becomes a root
      logic load_rsp;   // move the result into the output register
   } ctl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            a_ok;
      logic            b_ok;
      logic            at_root;
      logic            roots_differ;
      logic            rsp_free;
   } dp_status_type;

endpackage

// File: rtl/core/ufea_ram.sv
// ----------------------------------------------------------------------------
// ufea_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ufea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ufea_ctrl.sv
// ----------------------------------------------------------------------------
// ufea_ctrl
// Controller: sequences range check, one or two chain walks, link or clear, and response.
// ----------------------------------------------------------------------------
module ufea_ctrl
   import ufea_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_accept,
   input  dp_status_type status,
   output logic          idle,
   output ctl_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD_A,
      ST_CK_A,
      ST_RD_B,
      ST_CK_B,
      ST_LINK,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.op)
               OP_EDGE: begin
                  if (status.a_ok && status.b_ok) begin
                     state_in = ST_RD_A;
                  end else begin
                     cmd.set_err = 1'b1;
                     state_in    = ST_DONE;
                  end
               end
               OP_FIND: begin
                  if (status.a_ok) begin
                     state_in = ST_RD_A;
                  end else begin
                     cmd.set_err = 1'b1;
                     state_in    = ST_DONE;
                  end
               end
               OP_CLEAR: begin
                  cmd.clr_forest = 1'b1;
                  state_in       = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_RD_A: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_CK_A;
         end
         ST_CK_A: begin
            if (status.at_root) begin
               cmd.save_a = 1'b1;
               if (status.op == OP_EDGE) begin
                  cmd.sel_b = 1'b1;
                  state_in  = ST_RD_B;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               cmd.step = 1'b1;
               state_in = ST_RD_A;
            end
         end
         ST_RD_B: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_CK_B;
         end
         ST_CK_B: begin
            if (status.at_root) begin
               cmd.save_b = 1'b1;
               state_in   = ST_LINK;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_RD_B;
            end
         end
         ST_LINK: begin
            cmd.link = status.roots_differ;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);

endmodule

// File: rtl/core/ufea_dpath.sv
// ----------------------------------------------------------------------------
// ufea_dpath
// Datapath: node count register, parent link memory, linked bits, walk pointer, result and
// output register.
// ----------------------------------------------------------------------------
module ufea_dpath
   import ufea_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctl_cmd_type        cmd,
   output dp_status_type      status,
   input  logic [OP_W-1:0]    req_op,
   input  logic [NODE_W-1:0]  req_a,
   input  logic [NODE_W-1:0]  req_b,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata
);

   logic [COUNT_W-1:0]   node_count_ff;
   logic [OP_W-1:0]      op_ff;
   logic [NODE_W-1:0]    a_ff;
   logic [NODE_W-1:0]    b_ff;
   logic [NODE_W-1:0]    cur_ff;
   logic [MAX_NODES-1:0] linked_ff;
   logic                 linked_rd_ff;
   logic [NODE_W-1:0]    root_a_ff;
   logic [NODE_W-1:0]    root_b_ff;
   logic                 acc_ff;
   logic                 err_ff;
   logic                 rsp_valid_ff;
   logic [23:0]          rsp_data_ff;
   logic [COUNT_W-1:0]   limit;
   logic [NODE_W-1:0]    ram_q;
   logic [NODE_W-1:0]    up;

   // nodes in use, capped at the forest size
   assign limit = (node_count_ff > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
                                                         : node_count_ff;

   // parent links; an entry holds a parent only while its linked bit is set
   ufea_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_NODES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.link),
      .wr_addr (root_b_ff),
      .wr_data (root_a_ff),
      .rd_en   (cmd.rd_issue),
      .rd_addr (cur_ff),
      .rd_data (ram_q)
   );

   // an unlinked node is its own parent
   assign up = linked_rd_ff ? ram_q : cur_ff;

   // node count register
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // linked bits, cleared by reset and by a clear item
   always_ff @(posedge clock) begin
      if (reset || cmd.clr_forest) begin
         linked_ff <= '0;
      end else if (cmd.link) begin
         linked_ff[root_b_ff] <= 1'b1;
      end
   end

   // item, walk pointer and result under construction
   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         linked_rd_ff <= linked_ff[cur_ff];
      end
      if (cmd.load_req) begin
         op_ff     <= req_op;
         a_ff      <= req_a;
         b_ff      <= req_b;
         cur_ff    <= req_a;
         root_a_ff <= '0;
         root_b_ff <= '0;
         acc_ff    <= 1'b0;
         err_ff    <= 1'b0;
      end else begin
         if (cmd.set_err) begin
            err_ff <= 1'b1;
         end
         if (cmd.step) begin
            cur_ff <= up;
         end
         if (cmd.save_a) begin
            root_a_ff <= cur_ff;
         end
         if (cmd.sel_b) begin
            cur_ff <= b_ff;
         end
         if (cmd.save_b) begin
            root_b_ff <= cur_ff;
         end
         if (cmd.link) begin
            acc_ff <= 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {6'd0, err_ff, root_b_ff, root_a_ff, acc_ff};
      end
   end

   // status to the controller
   assign status.op           = op_ff;
   assign status.a_ok         = ({1'b0, a_ff} < limit);
   assign status.b_ok         = ({1'b0, b_ff} < limit);
   assign status.at_root      = (up == cur_ff);
   assign status.roots_differ = (root_a_ff != root_b_ff);
   assign status.rsp_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/core/union_find_edge_acceptor.sv
// ----------------------------------------------------------------------------
// union_find_edge_acceptor
// Disjoint-set forest for the union step of a minimum spanning tree build:
// edge, find and clear items, roots found by walking parent links without
// compression.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tuser opcode, tdata endpoints
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata result fields
//  csr     | in        | csr_wr_en              | csr_wr_data node_count
//
// An edge walks the chains of endpoint_a and endpoint_b to their roots, a
// find only that of endpoint_a; each step up a chain costs one read of the
// link RAM, whose data is registered. Clear items and range errors go from
// decode straight to the response. Reset makes every node a root (linked bits).
// A waiting result does not block the next item; only the final load of
// the output register waits for it to be taken.
// ----------------------------------------------------------------------------
module union_find_edge_acceptor
   import ufea_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // endpoint_a [7:0], endpoint_b [15:8]
   input  logic [1:0]   req_tuser,   // opcode [1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,   // accepted [0], root_a [8:1], root_b [16:9],
                                     // range_error [17], zero [23:18]
   input  logic         csr_wr_en,
   input  logic [8:0]   csr_wr_data  // node_count
);

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          idle;

   // an item is taken whenever the controller is idle
   assign req_tready = idle;

   ufea_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_tvalid && idle),
      .status     (status),
      .idle       (idle),
      .cmd        (cmd)
   );

   ufea_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_op      (req_tuser),
      .req_a       (req_tdata[7:0]),
      .req_b       (req_tdata[15:8]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
